// ----- rtl/bss_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, codes and control structs of the bounded set store
package bss_pkg;

    localparam int BSS_DEPTH = 16;
    localparam int BSS_WIDTH = 32;
    localparam int CAP_W     = 5;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 4;
    localparam int CNT_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // take the input word, start a new scan
        logic scan;      // one step of the membership scan
        logic exec;      // apply add, or fetch last entry for a remove
        logic move;      // write last entry into freed slot
        logic out_load;  // load the result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;  // hit or end of list this cycle
        logic need_move;  // remove of a present value
        logic out_free;   // result register can take a word
    } t_dp_sts;

endpackage

// ----- rtl/bss_ram.sv -----
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module bss_ram
    import bss_pkg::*;
#(
    parameter int WIDTH = BSS_WIDTH,
    parameter int DEPTH = BSS_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bss_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer of the bounded set store: accept, scan, apply, move, deliver
module bss_ctrl
    import bss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EXEC = 5'b00100,
        S_MOVE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_move ? S_MOVE : S_DONE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/bss_datapath.sv -----
`timescale 1ns / 1ps
// datapath: member ram, count, limit register, scan pipeline, result register
module bss_datapath
    import bss_pkg::*;
#(
    parameter int DEPTH = BSS_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic                      i_cfg_we,
    input  logic [CAP_W-1:0]          i_cfg_data,
    input  logic [KIND_W-1:0]         i_in_kind,
    input  logic signed [BSS_WIDTH-1:0] i_in_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_out_found,
    output logic [POS_W-1:0]          o_out_position,
    output logic                      o_out_accepted,
    output logic [CNT_W-1:0]          o_out_member_count
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0]     r_cap;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [KIND_W-1:0]    r_kind;
    logic [BSS_WIDTH-1:0] r_value;
    logic [CW-1:0]        r_addr;
    logic                 r_chk_valid;
    logic [AW-1:0]        r_chk_idx;
    logic                 r_found;
    logic [AW-1:0]        r_slot;
    logic                 r_acc;
    logic                 r_ovalid;
    logic                 r_o_found;
    logic [POS_W-1:0]     r_o_pos;
    logic                 r_o_acc;
    logic [CNT_W-1:0]     r_o_cnt;

    logic                 issue;
    logic                 hit;
    logic                 miss;
    logic [CMPW-1:0]      cap_ext;
    logic [CMPW-1:0]      lim;
    logic                 can_add;
    logic                 do_add;
    logic                 do_rm;
    logic [CW-1:0]        last_idx;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [BSS_WIDTH-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [BSS_WIDTH-1:0] ram_rdata;

    // scan: issue a read per cycle, compare the word read in the cycle before
    assign issue = r_addr < r_count;
    assign hit   = r_chk_valid && (ram_rdata == r_value);
    assign miss  = !hit && !r_chk_valid && !issue;

    // limit above the depth saturates
    assign cap_ext = CMPW'(r_cap);
    assign lim     = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
    assign can_add = CMPW'(r_count) < lim;

    assign do_add   = i_cmd.exec && (r_kind == KIND_ADD) && !r_found && can_add;
    assign do_rm    = i_cmd.exec && (r_kind == KIND_REMOVE) && r_found;
    assign last_idx = r_count - CW'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = r_value;
        if (do_add) begin
            ram_we = 1'b1;
        end else if (i_cmd.move) begin
            ram_we    = 1'b1;
            ram_waddr = r_slot;
            ram_wdata = ram_rdata;
        end
    end

    assign ram_re    = (i_cmd.scan && issue) || do_rm;
    assign ram_raddr = i_cmd.scan ? r_addr[AW-1:0] : last_idx[AW-1:0];

    always_comb begin
        n_count = r_count;
        if (do_add) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.move) begin
            n_count = last_idx;
        end
    end

    bss_ram #(
        .WIDTH (BSS_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_chk_valid <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_count <= n_count;
            if (i_cmd.load) begin
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk_valid <= issue;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_kind;
            r_value <= i_in_value;
            r_addr  <= '0;
            r_acc   <= 1'b0;
        end
        if (i_cmd.scan) begin
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end
            r_chk_idx <= r_addr[AW-1:0];
            if (hit || miss) begin
                r_found <= hit;
                r_slot  <= hit ? r_chk_idx : '0;
            end
        end
        if (do_add || do_rm) begin
            r_acc <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_found <= r_found;
            r_o_pos   <= POS_W'(r_slot);
            r_o_acc   <= r_acc;
            r_o_cnt   <= CNT_W'(r_count);
        end
    end

    assign o_sts.scan_done = hit || miss;
    assign o_sts.need_move = do_rm;
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid        = r_ovalid;
    assign o_out_found        = r_o_found;
    assign o_out_position     = r_o_pos;
    assign o_out_accepted     = r_o_acc;
    assign o_out_member_count = r_o_cnt;

endmodule

// ----- rtl/bounded_set_store.sv -----
`timescale 1ns / 1ps
// top level of the bounded set store
//
//  channel | handshake                 | word
//  --------+---------------------------+------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_in_kind, i_in_value
//  out     | o_out_valid / i_out_ready | o_out_found, o_out_position,
//          |                           |   o_out_accepted, o_out_member_count
//  cfg     | i_cfg_we                  | i_cfg_data (capacity limit)
//
// the scan reads one ram entry per cycle through the single ram read port and
// compares it in the cycle after, so the time from accept to result grows with
// the slot of a hit, or with the member count on a miss
// one word is in work at a time; o_in_ready is high only between operations
// a finished word waits in the result register, the next word waits behind it
// synchronous active-low reset empties the set, limit 16; the ram is not cleared
module bounded_set_store
    import bss_pkg::*;
#(
    parameter int DEPTH = BSS_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CAP_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [KIND_W-1:0]           i_in_kind,
    input  logic signed [BSS_WIDTH-1:0] i_in_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_out_found,
    output logic [POS_W-1:0]            o_out_position,
    output logic                        o_out_accepted,
    output logic [CNT_W-1:0]            o_out_member_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    bss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // member storage, scan and result register
    bss_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_kind          (i_in_kind),
        .i_in_value         (i_in_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_found        (o_out_found),
        .o_out_position     (o_out_position),
        .o_out_accepted     (o_out_accepted),
        .o_out_member_count (o_out_member_count)
    );

endmodule

// ----- rtl/bss_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the bounded set store and their bind
module bss_checker
    import bss_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_out_found,
    input logic [POS_W-1:0]            o_out_position,
    input logic                        o_out_accepted,
    input logic [CNT_W-1:0]            o_out_member_count
);

    // a held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_found) && $stable(o_out_position)
            && $stable(o_out_accepted) && $stable(o_out_member_count))
        else $error("result word changed while stalled");

    // one word in work: no accept in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an operation is in work");

    // a miss reports slot zero
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_found |-> o_out_position == '0)
        else $error("nonzero slot on a miss");

    // an accepted add leaves at least one member
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_accepted && !o_out_found |-> o_out_member_count != '0)
        else $error("accepted add with empty set");

endmodule

bind bounded_set_store bss_checker u_bss_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_out_found        (o_out_found),
    .o_out_position     (o_out_position),
    .o_out_accepted     (o_out_accepted),
    .o_out_member_count (o_out_member_count)
);
